[hdl/clebs_pkg.sv]
`default_nettype none
package clebs_pkg;

	typedef enum logic [2:0] {
		FN_DATA   = 3'd0,
		FN_CMD    = 3'd1,
		FN_CURSOR = 3'd2,
		FN_DEC    = 3'd3,
		FN_CLEAR  = 3'd4
	} func_t;

	// one display byte waiting for the back end
	typedef struct packed {
		logic [7:0] dbyte;
		logic       rs;
		logic       last;
	} entry_t;

	// low nibble of the expander word: backlight, enable, RS
	localparam logic [3:0] CTL_DATA = 4'h9;
	localparam logic [3:0] CTL_CMD  = 4'h8;
	localparam logic [3:0] CTL_EN   = 4'h4;

	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_HOME   = 8'h80;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [6:0] LINE2_BASE = 7'h40;
	localparam logic [1:0] LINE2      = 2'd2;

	localparam int DEC_DIGITS = 5;
	localparam int STEP_W     = $clog2(DEC_DIGITS);
	localparam logic [STEP_W-1:0] DEC_LAST_STEP = STEP_W'(DEC_DIGITS - 1);

	// k times the weight of each decimal place, most significant first
	localparam logic [16:0] DEC_MULT [DEC_DIGITS][10] = '{
		'{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
		  17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000},
		'{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000,
		  17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
		'{17'd0, 17'd100, 17'd200, 17'd300, 17'd400,
		  17'd500, 17'd600, 17'd700, 17'd800, 17'd900},
		'{17'd0, 17'd10, 17'd20, 17'd30, 17'd40,
		  17'd50, 17'd60, 17'd70, 17'd80, 17'd90},
		'{17'd0, 17'd1, 17'd2, 17'd3, 17'd4,
		  17'd5, 17'd6, 17'd7, 17'd8, 17'd9}
	};

	// six expander words per display byte: three per nibble
	localparam int BYTE_STEPS = 6;
	localparam int NIB_STEPS  = 3;
	localparam int CNT_W      = $clog2(BYTE_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BYTE_STEPS - 1);
	localparam logic [CNT_W-1:0] CNT_LO   = CNT_W'(NIB_STEPS);
	localparam logic [CNT_W-1:0] CNT_EN_H = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_EN_L = CNT_W'(NIB_STEPS + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

endpackage
`default_nettype wire

[hdl/clebs_if.sv]
`default_nettype none
interface clebs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [7:0]  data_byte;
	logic [1:0]  line_number;
	logic [6:0]  column_number;
	logic [15:0] number_value;

	modport source (output valid, func, data_byte, line_number, column_number,
		number_value, input ready);
	modport sink (input valid, func, data_byte, line_number, column_number,
		number_value, output ready);
endinterface

interface clebs_exp_if;
	logic       valid;
	logic       ready;
	logic [7:0] expander_byte;
	logic       last_of_run;

	modport source (output valid, expander_byte, last_of_run, input ready);
	modport sink (input valid, expander_byte, last_of_run, output ready);
endinterface
`default_nettype wire

[hdl/clebs_front.sv]
`default_nettype none
module clebs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	clebs_req_if.sink           req,
	output clebs_pkg::entry_t   ent,
	output logic                ent_valid,
	input  wire logic           ent_ready
);
	import clebs_pkg::*;

	logic              busy_q;
	func_t             func_q;
	logic [7:0]        data_q;
	logic [15:0]       rem_q;
	logic [STEP_W-1:0] step_q;
	logic              started_q;

	logic        push;
	logic        final_step;
	logic        adv;
	logic        done;
	logic        accept;
	logic        func_ok;
	logic [3:0]  digit;
	logic [15:0] rem_nxt;
	logic [6:0]  cur_addr;
	logic [6:0]  line_base;

	// digit of the current place: count of multiples not above the remainder
	always_comb begin
		digit = '0;
		for (int k = 1; k < 10; k++) begin
			if ({1'b0, rem_q} >= DEC_MULT[step_q][k])
				digit = digit + 4'd1;
		end
		rem_nxt = 16'({1'b0, rem_q} - DEC_MULT[step_q][digit]);
	end

	always_comb begin
		push       = 1'b0;
		final_step = 1'b1;
		ent        = '{dbyte: data_q, rs: 1'b0, last: 1'b1};
		unique case (func_q)
			FN_DATA: begin
				push   = 1'b1;
				ent.rs = 1'b1;
			end
			FN_CMD, FN_CURSOR: begin
				push = 1'b1;
			end
			FN_CLEAR: begin
				push       = 1'b1;
				final_step = step_q[0];
				ent.dbyte  = step_q[0] ? CMD_HOME : CMD_CLEAR;
				ent.last   = step_q[0];
			end
			FN_DEC: begin
				final_step = (step_q == DEC_LAST_STEP);
				// leading zeros suppressed; the units digit always goes out
				push       = started_q || (digit != 4'd0) || final_step;
				ent.dbyte  = ASCII_ZERO | {4'd0, digit};
				ent.rs     = 1'b1;
				ent.last   = final_step;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign ent_valid = busy_q && push;
	assign adv       = busy_q && (!push || ent_ready);
	assign done      = adv && final_step;
	assign req.ready = !busy_q || done;
	assign accept    = req.valid && req.ready;

	assign func_ok   = (req.func <= FN_CLEAR);
	assign line_base = (req.line_number == LINE2) ? LINE2_BASE : 7'd0;
	assign cur_addr  = line_base + req.column_number - 7'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			started_q <= 1'b0;
		end else if (accept) begin
			busy_q    <= func_ok;
			step_q    <= '0;
			started_q <= 1'b0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			step_q    <= step_q + STEP_W'(1);
			started_q <= started_q || (digit != 4'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(req.func);
			data_q <= (req.func == FN_CURSOR) ? {1'b1, cur_addr} : req.data_byte;
			rem_q  <= req.number_value;
		end else if (adv) begin
			rem_q <= rem_nxt;
		end
	end

endmodule
`default_nettype wire

[hdl/clebs_queue.sv]
`default_nettype none
module clebs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  clebs_pkg::entry_t     wr_ent,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	output clebs_pkg::entry_t     rd_ent,
	output logic                  rd_valid,
	input  wire logic             rd_ready
);
	import clebs_pkg::*;

	entry_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign wr_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_ent   = mem[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_ent;
	end

endmodule
`default_nettype wire

[hdl/clebs_back.sv]
`default_nettype none
module clebs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  clebs_pkg::entry_t   ent,
	input  wire logic           ent_valid,
	output logic                ent_ready,
	clebs_exp_if.source         exp
);
	import clebs_pkg::*;

	logic             busy_q;
	entry_t           ent_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       nib;
	logic [3:0]       ctl;
	logic             en;
	logic             take;

	// high nibble first; enable pulses on the middle word of each nibble
	assign nib = (cnt_q < CNT_LO) ? ent_q.dbyte[7:4] : ent_q.dbyte[3:0];
	assign en  = (cnt_q == CNT_EN_H) || (cnt_q == CNT_EN_L);
	assign ctl = (ent_q.rs ? CTL_DATA : CTL_CMD) | (en ? CTL_EN : 4'd0);

	assign exp.valid         = busy_q;
	assign exp.expander_byte = {nib, ctl};
	assign exp.last_of_run   = ent_q.last && (cnt_q == CNT_LAST);

	assign take      = !busy_q || (exp.ready && (cnt_q == CNT_LAST));
	assign ent_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= ent_valid;
			cnt_q  <= '0;
		end else if (exp.ready) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			ent_q <= ent;
	end

endmodule
`default_nettype wire

[hdl/char_lcd_expander_byte_sequencer.sv]
// Turns character-LCD requests (character, command, cursor set, 16-bit
// decimal, clear) into expander words for a 4-bit display: each display byte
// goes out as six words, high nibble then low, each nibble as enable low,
// high, low, with backlight set and RS high for data. The output runs at one
// word per cycle while the expander is ready; a character, command or cursor
// set is one display byte, a clear two, a decimal one to five. The front end
// makes a clear as clear then home and a decimal one digit at a time, most
// significant first, and queues display bytes four deep, so it takes the next
// request while earlier words are still being sent; the six-word sequencer at
// the output sets the throughput. Codes 5 to 7 produce nothing.
`default_nettype none
module char_lcd_expander_byte_sequencer (
	input  wire logic   clk,
	input  wire logic   arst_n,
	clebs_req_if.sink   req,
	clebs_exp_if.source exp
);
	import clebs_pkg::*;

	entry_t f_ent;
	logic   f_valid;
	logic   f_ready;
	entry_t b_ent;
	logic   b_valid;
	logic   b_ready;

	clebs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ent       (f_ent),
		.ent_valid (f_valid),
		.ent_ready (f_ready)
	);

	clebs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_ent   (f_ent),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_ent   (b_ent),
		.rd_valid (b_valid),
		.rd_ready (b_ready)
	);

	clebs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent       (b_ent),
		.ent_valid (b_valid),
		.ent_ready (b_ready),
		.exp       (exp)
	);

endmodule
`default_nettype wire

[hdl/clebs_checker.sv]
`default_nettype none
module clebs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       exp_valid,
	input wire logic       exp_ready,
	input wire logic [7:0] exp_byte,
	input wire logic       exp_last
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && !exp_ready |=> exp_valid && $stable(exp_byte) && $stable(exp_last))
		else $error("output word changed while stalled");

	// backlight always on, unused bit clear
	a_ctl: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid |-> exp_byte[3] && !exp_byte[1])
		else $error("bad control bits in expander word");

	// a run always ends on an enable-low word
	a_last_en: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && exp_last |-> !exp_byte[2])
		else $error("run ends with enable high");

	// enable high is followed by enable low with the same nibble
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		exp_valid && exp_ready && exp_byte[2] |=>
			exp_valid && !exp_byte[2] && (exp_byte[7:4] == $past(exp_byte[7:4])))
		else $error("enable pulse not closed correctly");

endmodule

bind char_lcd_expander_byte_sequencer clebs_checker u_clebs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.exp_valid (exp.valid),
	.exp_ready (exp.ready),
	.exp_byte  (exp.expander_byte),
	.exp_last  (exp.last_of_run)
);
`default_nettype wire
